FILE: hdl/dfalx_pkg.sv
package dfalx_pkg;

  localparam int unsigned STATE_W    = 8;
  localparam int unsigned CLASS_W    = 6;
  localparam int unsigned CHAR_W     = 21;
  localparam int unsigned CT_AW      = 8;
  localparam int unsigned TT_AW      = STATE_W + CLASS_W;
  localparam int unsigned ACC_W      = 9;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned TOK_AW     = 5;
  localparam int unsigned LEN_W      = TOK_AW + 1;
  localparam int unsigned ROW_W      = 24;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [LEN_W-1:0]  MAX_TOKEN = LEN_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_NL   = CHAR_W'(10);

  localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CHAR   = 3'd0,
    OP_CLASS  = 3'd1,
    OP_TRANS  = 3'd2,
    OP_ACCEPT = 3'd3,
    OP_EOI    = 3'd4
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [CHAR_W-1:0]        char_code;
    logic [STATE_W-1:0]       state_index;
    logic [CLASS_W-1:0]       class_index;
    logic                     next_valid;
    logic [STATE_W-1:0]       next_state;
    logic signed [ACC_W-1:0]  accept_code;
  } item_t;

endpackage

FILE: hdl/dfalx_front.sv
module dfalx_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dfalx_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [dfalx_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                              q_valid_o,
  output dfalx_pkg::item_t                  q_item_o,
  input  logic                              q_pop_i
);
  import dfalx_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  item_t      item;
  logic       keep;
  logic       push;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_item_o      = fifo_q[rd_ptr_q];

  always_comb begin
    item.char_code   = s_axis_tdata[20:0];
    item.state_index = s_axis_tdata[28:21];
    item.class_index = s_axis_tdata[34:29];
    item.next_valid  = s_axis_tdata[35];
    item.next_state  = s_axis_tdata[43:36];
    item.accept_code = s_axis_tdata[52:44];
    item.op          = OP_CHAR;
    keep             = 1'b1;
    // unused op codes and class writes beyond the table are dropped here
    unique case (s_axis_tuser)
      OP_CHAR:   item.op = OP_CHAR;
      OP_CLASS: begin
        item.op = OP_CLASS;
        keep    = (s_axis_tdata[20:CT_AW] == '0);
      end
      OP_TRANS:  item.op = OP_TRANS;
      OP_ACCEPT: item.op = OP_ACCEPT;
      OP_EOI:    item.op = OP_EOI;
      default:   keep    = 1'b0;
    endcase
  end

  assign push = s_axis_tvalid && s_axis_tready && keep;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

FILE: hdl/dfalx_back.sv
module dfalx_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [dfalx_pkg::CLASS_W-1:0]      other_class_i,
  input  logic                               q_valid_i,
  input  dfalx_pkg::item_t                   q_item_i,
  output logic                               q_pop_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dfalx_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [dfalx_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);
  import dfalx_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLS    = 4'd1;
  localparam logic [3:0] S_TRN    = 4'd2;
  localparam logic [3:0] S_PEEK   = 4'd3;
  localparam logic [3:0] S_APPLY  = 4'd4;
  localparam logic [3:0] S_DRN_RD = 4'd5;
  localparam logic [3:0] S_DRN_WR = 4'd6;
  localparam logic [3:0] S_CERR   = 4'd7;
  localparam logic [3:0] S_EOI    = 4'd8;
  localparam logic [3:0] S_EERR   = 4'd9;
  localparam logic [3:0] S_END    = 4'd10;

  logic [CLASS_W-1:0]      class_mem  [2**CT_AW];
  logic [STATE_W:0]        trans_mem  [2**TT_AW];
  logic [ACC_W-1:0]        accept_mem [2**STATE_W];
  logic [CHAR_W-1:0]       tok_mem    [2**TOK_AW];

  logic [CLASS_W-1:0]      ct_rd_q;
  logic [STATE_W:0]        tt_rd_q;
  logic [ACC_W-1:0]        at_rd_q;
  logic [CHAR_W-1:0]       tok_rd_q;

  logic [3:0]              fsm_q, fsm_d;
  item_t                   item_q;
  logic [STATE_W-1:0]      state_q, state_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic                    nl_q, nl_d;
  logic [CLASS_W-1:0]      cls_q, cls_d;
  logic [TYPE_W-1:0]       type_q, type_d;
  logic                    rs_valid_q, rs_valid_d;
  logic [STATE_W-1:0]      rs_ns_q, rs_ns_d;
  logic [LEN_W-1:0]        idx_q, idx_d;
  logic                    eoi_q, eoi_d;

  logic                    out_valid_q;
  logic [KIND_W-1:0]       out_kind_q;
  logic [TYPE_W-1:0]       out_type_q;
  logic [CHAR_W-1:0]       out_char_q;
  logic [ROW_W-1:0]        out_row_q;
  logic [COL_W-1:0]        out_col_q;
  logic                    out_last_q;

  logic                    emit;
  logic [KIND_W-1:0]       e_kind;
  logic [TYPE_W-1:0]       e_type;
  logic [CHAR_W-1:0]       e_char;
  logic                    e_last;
  logic                    out_free;

  logic [CLASS_W-1:0]      cls_now;
  logic [TT_AW-1:0]        tt_raddr;
  logic                    bw_en;
  logic [TOK_AW-1:0]       bw_addr;
  logic                    consume;
  logic [ROW_W-1:0]        row_c;
  logic [COL_W-1:0]        col_b, col_c;
  logic signed [ACC_W-1:0] acc;

  assign out_free = !out_valid_q || m_axis_tready;
  assign cls_now  = (item_q.char_code[CHAR_W-1:CT_AW] == '0) ? ct_rd_q : other_class_i;
  assign tt_raddr = (fsm_q == S_CLS) ? {state_q, cls_now} : {STATE_W'(0), cls_q};
  assign acc      = at_rd_q;

  // row and column after consuming the current character
  always_comb begin
    row_c = row_q;
    col_b = col_q;
    if (nl_q) begin
      if (row_q != '1) row_c = row_q + ROW_W'(1);
      col_b = '0;
    end
    col_c = (col_b != '1) ? col_b + COL_W'(1) : col_b;
  end

  always_ff @(posedge clk_i) begin
    ct_rd_q  <= class_mem[q_item_i.char_code[CT_AW-1:0]];
    tt_rd_q  <= trans_mem[tt_raddr];
    at_rd_q  <= accept_mem[state_q];
    tok_rd_q <= tok_mem[idx_q[TOK_AW-1:0]];
    if (fsm_q == S_IDLE && q_valid_i) begin
      if (q_item_i.op == OP_CLASS) begin
        class_mem[q_item_i.char_code[CT_AW-1:0]] <= q_item_i.class_index;
      end
      if (q_item_i.op == OP_TRANS) begin
        trans_mem[{q_item_i.state_index, q_item_i.class_index}] <=
          {q_item_i.next_valid, q_item_i.next_state};
      end
      if (q_item_i.op == OP_ACCEPT) begin
        accept_mem[q_item_i.state_index] <= q_item_i.accept_code;
      end
    end
    if (bw_en) begin
      tok_mem[bw_addr] <= item_q.char_code;
    end
  end

  always_comb begin
    fsm_d      = fsm_q;
    state_d    = state_q;
    len_d      = len_q;
    cls_d      = cls_q;
    type_d     = type_q;
    rs_valid_d = rs_valid_q;
    rs_ns_d    = rs_ns_q;
    idx_d      = idx_q;
    eoi_d      = eoi_q;
    q_pop_o    = 1'b0;
    bw_en      = 1'b0;
    bw_addr    = len_q[TOK_AW-1:0];
    consume    = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_TOKEN;
    e_type     = '0;
    e_char     = '0;
    e_last     = 1'b0;
    unique case (fsm_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == OP_CHAR) begin
            fsm_d = S_CLS;
          end else if (q_item_i.op == OP_EOI) begin
            fsm_d = (len_q != '0) ? S_EOI : S_END;
          end
        end
      end
      S_CLS: begin
        cls_d = cls_now;
        fsm_d = S_TRN;
      end
      S_TRN: begin
        if (tt_rd_q[STATE_W]) begin
          if (len_q == MAX_TOKEN) begin
            fsm_d = S_CERR;
          end else begin
            bw_en   = 1'b1;
            len_d   = len_q + LEN_W'(1);
            state_d = tt_rd_q[STATE_W-1:0];
            consume = 1'b1;
            fsm_d   = S_IDLE;
          end
        end else if (len_q == '0 || acc[ACC_W-1]) begin
          fsm_d = S_CERR;
        end else begin
          // accepting or skip state: look up the rescan from state 0 first
          type_d = acc[TYPE_W-1:0];
          fsm_d  = S_PEEK;
        end
      end
      S_PEEK: begin
        rs_valid_d = tt_rd_q[STATE_W];
        rs_ns_d    = tt_rd_q[STATE_W-1:0];
        idx_d      = '0;
        eoi_d      = 1'b0;
        fsm_d      = (type_q != '0) ? S_DRN_RD : S_APPLY;
      end
      S_APPLY: begin
        if (rs_valid_q) begin
          bw_en   = 1'b1;
          bw_addr = '0;
          len_d   = LEN_W'(1);
          state_d = rs_ns_q;
          consume = 1'b1;
          fsm_d   = S_IDLE;
        end else begin
          len_d   = '0;
          state_d = '0;
          fsm_d   = S_CERR;
        end
      end
      S_DRN_RD: begin
        fsm_d = S_DRN_WR;
      end
      S_DRN_WR: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_TOKEN;
          e_type = type_q;
          e_char = tok_rd_q;
          e_last = (idx_q + LEN_W'(1) == len_q) && !eoi_q && rs_valid_q;
          idx_d  = idx_q + LEN_W'(1);
          if (idx_q + LEN_W'(1) == len_q) begin
            fsm_d = eoi_q ? S_END : S_APPLY;
          end else begin
            fsm_d = S_DRN_RD;
          end
        end
      end
      S_CERR: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KIND_ERROR;
          e_char  = item_q.char_code;
          e_last  = 1'b1;
          consume = 1'b1;
          len_d   = '0;
          state_d = '0;
          fsm_d   = S_IDLE;
        end
      end
      S_EOI: begin
        type_d = acc[TYPE_W-1:0];
        idx_d  = '0;
        eoi_d  = 1'b1;
        if (acc[ACC_W-1]) begin
          fsm_d = S_EERR;
        end else if (acc != '0) begin
          fsm_d = S_DRN_RD;
        end else begin
          fsm_d = S_END;
        end
      end
      S_EERR: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_ERROR;
          fsm_d  = S_END;
        end
      end
      S_END: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KIND_END;
          e_last  = 1'b1;
          len_d   = '0;
          state_d = '0;
          fsm_d   = S_IDLE;
        end
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  assign row_d = consume ? row_c : row_q;
  assign col_d = consume ? col_c : col_q;
  assign nl_d  = consume ? (item_q.char_code == CHAR_NL) : nl_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
    cls_q   <= cls_d;
    type_q  <= type_d;
    rs_ns_q <= rs_ns_d;
    if (emit) begin
      out_kind_q <= e_kind;
      out_type_q <= e_type;
      out_char_q <= e_char;
      out_row_q  <= consume ? row_c : row_q;
      out_col_q  <= consume ? col_c : col_q;
      out_last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      state_q     <= '0;
      len_q       <= '0;
      row_q       <= ROW_W'(1);
      col_q       <= '0;
      nl_q        <= 1'b0;
      rs_valid_q  <= 1'b0;
      idx_q       <= '0;
      eoi_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      state_q    <= state_d;
      len_q      <= len_d;
      row_q      <= row_d;
      col_q      <= col_d;
      nl_q       <= nl_d;
      rs_valid_q <= rs_valid_d;
      idx_q      <= idx_d;
      eoi_q      <= eoi_d;
      if (emit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_col_q, out_row_q, out_char_q, out_type_q};

endmodule

FILE: hdl/table_driven_dfa_lexer.sv
// Table-driven DFA lexer. Items enter a two-entry queue and are worked off
// one at a time by a sequencer over block memories (class, transition, accept,
// token buffer), each read through a registered output. Table writes are
// applied from the queue; ignored ops never reach it, as the input side drops
// them. A character is classified and buffered; a dead transition ends the
// token, which is emitted per character (none for a skip) before the character
// is rescanned from state 0, or the character is an error. End of input emits
// the pending token (an error for an error state), then the end result (tlast set).
// Tables power up undefined and must be loaded before characters are sent.
module table_driven_dfa_lexer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dfalx_pkg::CLASS_W-1:0]     cfg_wdata_i,    // other_char_class
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // char_code[20:0], state_index[28:21], class_index[34:29], next_valid[35],
  // next_state[43:36], accept_code[52:44]
  input  logic [dfalx_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [dfalx_pkg::OP_W-1:0]        s_axis_tuser,   // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // token_type[7:0], token_char[28:8], row[52:29], column[68:53]
  output logic [dfalx_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [dfalx_pkg::KIND_W-1:0]      m_axis_tuser,   // kind
  output logic                              m_axis_tlast
);
  import dfalx_pkg::*;

  logic [CLASS_W-1:0] other_q;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      other_q <= '0;
    end else if (cfg_we_i) begin
      other_q <= cfg_wdata_i;
    end
  end

  dfalx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  dfalx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .other_class_i (other_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: dv/tb_table_driven_dfa_lexer.sv
`default_nettype none

module tb_table_driven_dfa_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import dfalx_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int USED_STATES   = 8;
  localparam int USED_CLASSES  = 8;
  localparam int CLASS_CODES   = 48;
  localparam int BASE_CLASSES  = 6;
  localparam int RANDOM_ITEMS  = 72;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TYPE_W-1:0] ttype;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } lex_result_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CLASS_W-1:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [OP_W-1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  table_driven_dfa_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // lexer shadow state
  logic [CLASS_W-1:0]      class_of[256];
  logic [8:0]              next_of[1 << TT_AW];
  logic signed [ACC_W-1:0] accept_of[256];
  logic [CLASS_W-1:0]      other_class;
  logic [STATE_W-1:0]      cur_state;
  logic [CHAR_W-1:0]       tok_chars[32];
  int unsigned             tok_len;
  int unsigned             cur_row, cur_col;
  bit                      after_newline;

  lex_result_t lex_results_q[$];
  int  fail_count;
  int  cycle_count;
  bit  tx_idle_en, rx_idle_en;
  int  rx_hold_cycles;
  int  rx_gap;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_result(logic [KIND_W-1:0] kind, logic [TYPE_W-1:0] ttype,
                                      logic [CHAR_W-1:0] ch);
    lex_result_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.ch    = ch;
    r.row   = cur_row[ROW_W-1:0];
    r.col   = cur_col[COL_W-1:0];
    r.last  = 1'b0;
    lex_results_q = {lex_results_q, r};
  endfunction

  function automatic void consume_char(logic [CHAR_W-1:0] ch);
    if (after_newline) begin
      if (cur_row < 24'hFFFFFF) cur_row++;
      cur_col = 0;
    end
    if (cur_col < 16'hFFFF) cur_col++;
    after_newline = (ch == CHAR_NL);
  endfunction

  // advances the shadow lexer by one accepted item and queues what it emits
  function automatic void lex_predict(item_t it);
    int base_size;
    logic [CLASS_W-1:0] cls;
    logic [8:0] entry;
    logic signed [ACC_W-1:0] acc;
    base_size = lex_results_q.size();
    case (it.op)
      OP_CLASS:  if (it.char_code < 256) class_of[it.char_code] = it.class_index;
      OP_TRANS:  next_of[{it.state_index, it.class_index}] = {it.next_valid, it.next_state};
      OP_ACCEPT: accept_of[it.state_index] = it.accept_code;
      OP_EOI: begin
        if (tok_len > 0) begin
          acc = accept_of[cur_state];
          if (acc > 0) begin
            for (int i = 0; i < tok_len; i++) push_result(KIND_TOKEN, acc[7:0], tok_chars[i]);
          end else if (acc < 0) push_result(KIND_ERROR, '0, '0);
        end
        cur_state = '0;
        tok_len = 0;
        push_result(KIND_END, '0, '0);
      end
      OP_CHAR: begin
        for (int pass = 0; pass < 2; pass++) begin
          cls = (it.char_code < 256) ? class_of[it.char_code] : other_class;
          entry = next_of[{cur_state, cls}];
          if (entry[8]) begin
            if (tok_len >= MAX_TOKEN) begin
              consume_char(it.char_code);
              push_result(KIND_ERROR, '0, it.char_code);
              cur_state = '0;
              tok_len = 0;
            end else begin
              tok_chars[tok_len] = it.char_code;
              tok_len++;
              cur_state = entry[7:0];
              consume_char(it.char_code);
            end
            break;
          end
          acc = accept_of[cur_state];
          if (tok_len == 0 || acc < 0) begin
            consume_char(it.char_code);
            push_result(KIND_ERROR, '0, it.char_code);
            cur_state = '0;
            tok_len = 0;
            break;
          end
          if (acc > 0) begin
            for (int i = 0; i < tok_len; i++) push_result(KIND_TOKEN, acc[7:0], tok_chars[i]);
          end
          cur_state = '0;
          tok_len = 0;
        end
      end
      default: ;
    endcase
    if (lex_results_q.size() > base_size) lex_results_q[lex_results_q.size() - 1].last = 1'b1;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(item_t it);
    int gap;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.op;
    s_axis_tdata  = {3'b000, it.accept_code, it.next_state, it.next_valid,
                     it.class_index, it.state_index, it.char_code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lex_predict(it);
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {IN_DATA_W{1'b1}} ^ s_axis_tdata;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic item_t make_item(op_e op);
    item_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  task automatic send_char(logic [CHAR_W-1:0] ch);
    item_t it;
    it = make_item(OP_CHAR);
    it.char_code = ch;
    send_item(it);
  endtask

  task automatic write_class(logic [CHAR_W-1:0] idx, logic [CLASS_W-1:0] cls);
    item_t it;
    it = make_item(OP_CLASS);
    it.char_code = idx;
    it.class_index = cls;
    send_item(it);
  endtask

  task automatic write_trans(logic [STATE_W-1:0] st, logic [CLASS_W-1:0] cls, logic valid,
                             logic [STATE_W-1:0] target);
    item_t it;
    it = make_item(OP_TRANS);
    it.state_index = st;
    it.class_index = cls;
    it.next_valid = valid;
    it.next_state = target;
    send_item(it);
  endtask

  task automatic write_accept(logic [STATE_W-1:0] st, logic signed [ACC_W-1:0] code);
    item_t it;
    it = make_item(OP_ACCEPT);
    it.state_index = st;
    it.accept_code = code;
    send_item(it);
  endtask

  task automatic send_eoi();
    send_item(make_item(OP_EOI));
  endtask

  // a code point below CLASS_CODES whose initial class is cls
  function automatic logic [CHAR_W-1:0] char_of_class(int cls);
    return CHAR_W'(BASE_CLASSES * $urandom_range(0, 7) + cls);
  endfunction

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (lex_results_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_other_class(logic [CLASS_W-1:0] cls);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = cls;
    @(negedge clk_i);
    other_class = cls;
    cfg_we_i = 1'b0;
  endtask

  // result side: random stalls, a long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_cycles--;
    end else if (rx_gap > 0) begin
      m_axis_tready = 1'b0;
      rx_gap--;
    end else begin
      m_axis_tready = 1'b1;
      if (rx_idle_en && $urandom_range(0, 4) == 0)
        rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    lex_result_t want;
    lex_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind  = m_axis_tuser;
      got.ttype = m_axis_tdata[7:0];
      got.ch    = m_axis_tdata[28:8];
      got.row   = m_axis_tdata[52:29];
      got.col   = m_axis_tdata[68:53];
      got.last  = m_axis_tlast;
      if (lex_results_q.size() == 0) begin
        $display("%0t: unexpected transaction kind=%0d type=%0d char=%0h", $time,
                 got.kind, got.ttype, got.ch);
        fail_count++;
      end else begin
        want = lex_results_q.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
          fail_count++;
        end
        if (got.ttype !== want.ttype) begin
          $display("%0t: token_type expected %0d actual %0d", $time, want.ttype, got.ttype);
          fail_count++;
        end
        if (got.ch !== want.ch) begin
          $display("%0t: token_char expected %0h actual %0h", $time, want.ch, got.ch);
          fail_count++;
        end
        if (got.row !== want.row) begin
          $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
          fail_count++;
        end
        if (got.col !== want.col) begin
          $display("%0t: column expected %0d actual %0d", $time, want.col, got.col);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // identifiers (state 1), numbers (2), blanks skipped (3), a non-accepting prefix (4)
  task automatic test_load_tables();
    logic [8:0] entry;
    for (int ch = 0; ch < CLASS_CODES; ch++)
      write_class(CHAR_W'(ch), CLASS_W'(ch % BASE_CLASSES));
    for (int st = 0; st < USED_STATES; st++) begin
      for (int cls = 0; cls < USED_CLASSES; cls++) begin
        entry = '0;
        case (st)
          0: case (cls)
               0: entry = {1'b1, 8'd4};
               1: entry = {1'b1, 8'd1};
               2: entry = {1'b1, 8'd2};
               3, 4: entry = {1'b1, 8'd3};
               default: ;
             endcase
          1: if (cls == 1 || cls == 2) entry = {1'b1, 8'd1};
          2: if (cls == 2) entry = {1'b1, 8'd2};
          3: if (cls == 3 || cls == 4) entry = {1'b1, 8'd3};
          4: ;
          default: if ($urandom_range(0, 2) == 0)
                     entry = {1'b1, 8'($urandom_range(0, USED_STATES - 1))};
        endcase
        write_trans(STATE_W'(st), CLASS_W'(cls), entry[8], entry[7:0]);
      end
    end
    write_accept(8'd0, -9'sd1);
    write_accept(8'd1, 9'sd5);
    write_accept(8'd2, 9'sd254);
    write_accept(8'd3, 9'sd0);
    write_accept(8'd4, -9'sd1);
    for (int st = 5; st < USED_STATES; st++)
      write_accept(STATE_W'(st), ACC_W'($urandom_range(0, 255)) - 9'sd1);
  endtask

  task automatic test_directed();
    write_trans(8'hFF, 6'h3F, 1'b1, 8'hFF);
    write_accept(8'hFF, 9'sd254);
    write_class(21'h1FFFFF, 6'h2A);
    write_class(21'd256, 6'h15);
    send_char(21'd37);       // identifier
    send_char(21'd38);
    send_char(21'd3);        // blank ends it, blanks get skipped
    send_char(CHAR_NL);      // newline inside a skipped run
    send_char(21'd8);        // number, row advanced
    send_char(21'd5);        // error class ends the number, then errors itself
    send_char(21'd5);        // error with nothing buffered
    send_char(21'd0);        // non-accepting prefix
    send_char(21'd1);        // dead there: error
    send_char(21'h1FFFFF);   // above the class table, other class 0
    send_char(21'd13);
    send_eoi();              // nothing pending, as 13 was an error
    send_char(21'd0);
    send_eoi();              // pending error state
    send_char(21'd3);
    send_eoi();              // pending skip
    send_eoi();              // nothing pending
    for (int k = OP_EOI + 1; k < 8; k++) send_item(make_item(op_e'(k)));
    set_other_class(6'h07);
    send_char(21'h100000);
    send_char(21'd300);
    send_eoi();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 34; i++) send_char(char_of_class(1));
    send_char(char_of_class(3));
    for (int i = 0; i < 32; i++) send_char(char_of_class(2));
    send_char(char_of_class(0));
    send_eoi();
  endtask

  task automatic test_backpressure();
    wait_idle();
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_char(char_of_class(i % 3 == 0 ? 3 : 1));
    send_eoi();
  endtask

  task automatic test_random(int n_items);
    int sent;
    int run;
    int cls;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        0: begin
          send_char(CHAR_W'($urandom_range(256, 21'h1FFFFF)));
          sent++;
        end
        1: begin
          send_eoi();
          sent++;
        end
        2: begin
          write_class(($urandom_range(0, 7) == 0) ? CHAR_W'($urandom_range(256, 21'h1FFFFF))
                                                  : CHAR_W'($urandom_range(0, CLASS_CODES - 1)),
                      CLASS_W'($urandom_range(0, USED_CLASSES - 1)));
          sent++;
        end
        3: begin
          if ($urandom_range(0, 1))
            write_trans(STATE_W'($urandom_range(0, USED_STATES - 1)),
                        CLASS_W'($urandom_range(0, USED_CLASSES - 1)),
                        1'($urandom_range(0, 1)),
                        STATE_W'($urandom_range(0, USED_STATES - 1)));
          else
            write_accept(STATE_W'($urandom_range(0, USED_STATES - 1)),
                         ACC_W'($urandom_range(0, 255)) - 9'sd1);
          sent++;
        end
        default: begin
          cls = $urandom_range(0, BASE_CLASSES - 1);
          run = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
          for (int i = 0; i < run && sent < n_items; i++) begin
            send_char((cls == 4) ? CHAR_NL : char_of_class(cls));
            sent++;
          end
        end
      endcase
      if ($urandom_range(0, 40) == 0) begin
        tx_idle_en = ~tx_idle_en;
        rx_idle_en = $urandom_range(0, 1);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    rx_hold_cycles = 0;
    rx_gap = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    other_class = '0;
    cur_state = '0;
    tok_len = 0;
    cur_row = 1;
    cur_col = 0;
    after_newline = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_other_class(6'h00);
    test_load_tables();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_directed();
    test_overflow();
    test_backpressure();
    set_other_class(6'h02);
    test_random(RANDOM_ITEMS / 3);
    set_other_class(6'h07);
    test_random(RANDOM_ITEMS / 3);
    set_other_class(CLASS_W'($urandom_range(0, 5)));
    test_random(RANDOM_ITEMS / 3);

    s_axis_tvalid = 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
